/* rtl/mhpq_pkg.sv */
// Package for the binary max-heap priority queue.
// Holds request/response types, operation and status codes, and sizing constants.
// Used by max_heap_priority_queue.
package mhpq_pkg;

   localparam int HEAP_DEPTH  = 1024;
   localparam int VALUE_WIDTH = 32;
   localparam int ADDR_WIDTH  = $clog2(HEAP_DEPTH);
   localparam int CNT_WIDTH   = $clog2(HEAP_DEPTH + 1);
   localparam int POS_WIDTH   = CNT_WIDTH + 1;

   localparam logic OP_INSERT = 1'b0;
   localparam logic OP_REMOVE = 1'b1;

   localparam logic [1:0] ST_DONE  = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_EMPTY = 2'd2;

   typedef logic signed [VALUE_WIDTH-1:0] value_type;
   typedef logic [CNT_WIDTH-1:0]          count_type;
   typedef logic [POS_WIDTH-1:0]          pos_type;
   typedef logic [ADDR_WIDTH-1:0]         addr_type;

   typedef struct packed {
      logic      op;
      value_type item_value;
   } req_type;

   typedef struct packed {
      value_type  removed_value;
      logic [1:0] status;
      count_type  entries_after;
   } rsp_type;

endpackage

/* rtl/mhpq_ram.sv */
// Generic single-port synchronous RAM with registered read data.
// One access per cycle, write or read. No dependencies.
module mhpq_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic                     re,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem_ff[addr];
      end
   end

   assign rdata = rdata_ff;

endmodule

/* rtl/max_heap_priority_queue.sv */
// Binary max-heap priority queue: sequencer, entry count and response register.
// Depends on mhpq_pkg and mhpq_ram.
//
// Usage:
//   A request (req_payload: op, item_value) is taken at a rising edge with
//   start high and busy low. Insert adds item_value; remove takes the largest.
//   Exactly one response per request appears on rsp_payload for one cycle with
//   rsp_strobe high; busy is low in that same cycle.
//   Refused requests answer in the next cycle. An insert writes at the root
//   when it gets there, else reads the parent and climbs while larger (one RAM
//   read, one compare/write per level). A remove reads the root; on a one-entry
//   heap it answers then, else it reads the old last entry and descends until
//   it ends at a leaf or stops on a compare (left read, right read,
//   compare/write per level).
//   The single-port entry RAM allows one access per cycle.
//   Requests are handled one at a time.
//   Reset clears the count and the sequencer; entry contents need no clearing.
//   The receiver cannot stall: each response is valid for its single cycle.
module max_heap_priority_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  mhpq_pkg::req_type req_payload,
   output logic              rsp_strobe,
   output mhpq_pkg::rsp_type rsp_payload
);

   typedef enum logic [7:0] {
      S_IDLE    = 8'b0000_0001,
      S_UP_CHK  = 8'b0000_0010,
      S_UP_CMP  = 8'b0000_0100,
      S_RM_ROOT = 8'b0000_1000,
      S_RM_LAST = 8'b0001_0000,
      S_DN_CHK  = 8'b0010_0000,
      S_DN_LEFT = 8'b0100_0000,
      S_DN_CMP  = 8'b1000_0000
   } state_type;

   state_type           state_ff,   state_in;
   mhpq_pkg::count_type count_ff,   count_in;
   mhpq_pkg::pos_type   pos_ff,     pos_in;
   mhpq_pkg::value_type val_ff,     val_in;
   mhpq_pkg::value_type left_ff,    left_in;
   mhpq_pkg::value_type removed_ff, removed_in;
   logic                right_ok_ff, right_ok_in;
   logic                rsp_strobe_ff, rsp_strobe_in;
   mhpq_pkg::rsp_type   rsp_ff,     rsp_in;

   logic                mem_we;
   logic                mem_re;
   mhpq_pkg::addr_type  mem_addr;
   mhpq_pkg::value_type mem_wdata;
   mhpq_pkg::value_type mem_rdata;

   mhpq_pkg::pos_type   left_pos;
   mhpq_pkg::pos_type   right_pos;
   mhpq_pkg::pos_type   last_pos;
   mhpq_pkg::value_type child_val;
   mhpq_pkg::pos_type   child_pos;

   function automatic mhpq_pkg::addr_type slot_addr(input mhpq_pkg::pos_type p);
      mhpq_pkg::pos_type d;
      d = p - mhpq_pkg::POS_WIDTH'(1);
      return d[mhpq_pkg::ADDR_WIDTH-1:0];
   endfunction

   mhpq_ram #(
      .WIDTH (mhpq_pkg::VALUE_WIDTH),
      .DEPTH (mhpq_pkg::HEAP_DEPTH)
   ) u_store (
      .clock (clock),
      .we    (mem_we),
      .re    (mem_re),
      .addr  (mem_addr),
      .wdata (mem_wdata),
      .rdata (mem_rdata)
   );

   assign left_pos  = {pos_ff[mhpq_pkg::POS_WIDTH-2:0], 1'b0};
   assign right_pos = left_pos + mhpq_pkg::POS_WIDTH'(1);
   assign last_pos  = {1'b0, count_ff};

   always_comb begin
      if (right_ok_ff && ($signed(mem_rdata) > $signed(left_ff))) begin
         child_val = mem_rdata;
         child_pos = right_pos;
      end else begin
         child_val = left_ff;
         child_pos = left_pos;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      pos_in        = pos_ff;
      val_in        = val_ff;
      left_in       = left_ff;
      removed_in    = removed_ff;
      right_ok_in   = right_ok_ff;
      rsp_strobe_in = 1'b0;
      rsp_in        = rsp_ff;
      mem_we        = 1'b0;
      mem_re        = 1'b0;
      mem_addr      = '0;
      mem_wdata     = val_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               if (req_payload.op == mhpq_pkg::OP_INSERT) begin
                  if (count_ff == mhpq_pkg::CNT_WIDTH'(mhpq_pkg::HEAP_DEPTH)) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{removed_value: '0, status: mhpq_pkg::ST_FULL,
                                       entries_after: count_ff};
                  end else begin
                     count_in = count_ff + mhpq_pkg::CNT_WIDTH'(1);
                     pos_in   = last_pos + mhpq_pkg::POS_WIDTH'(1);
                     val_in   = req_payload.item_value;
                     state_in = S_UP_CHK;
                  end
               end else begin
                  if (count_ff == '0) begin
                     rsp_strobe_in = 1'b1;
                     rsp_in        = '{removed_value: '0, status: mhpq_pkg::ST_EMPTY,
                                       entries_after: count_ff};
                  end else begin
                     count_in = count_ff - mhpq_pkg::CNT_WIDTH'(1);
                     mem_re   = 1'b1;
                     mem_addr = '0;
                     state_in = S_RM_ROOT;
                  end
               end
            end
         end
         S_UP_CHK: begin
            if (pos_ff == mhpq_pkg::POS_WIDTH'(1)) begin
               mem_we        = 1'b1;
               mem_addr      = slot_addr(pos_ff);
               rsp_strobe_in = 1'b1;
               rsp_in        = '{removed_value: '0, status: mhpq_pkg::ST_DONE,
                                 entries_after: count_ff};
               state_in      = S_IDLE;
            end else begin
               mem_re   = 1'b1;
               mem_addr = slot_addr(pos_ff >> 1);
               state_in = S_UP_CMP;
            end
         end
         S_UP_CMP: begin
            mem_we   = 1'b1;
            mem_addr = slot_addr(pos_ff);
            if ($signed(val_ff) > $signed(mem_rdata)) begin
               mem_wdata = mem_rdata;
               pos_in    = pos_ff >> 1;
               state_in  = S_UP_CHK;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{removed_value: '0, status: mhpq_pkg::ST_DONE,
                                 entries_after: count_ff};
               state_in      = S_IDLE;
            end
         end
         S_RM_ROOT: begin
            removed_in = mem_rdata;
            if (count_ff == '0) begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{removed_value: mem_rdata, status: mhpq_pkg::ST_DONE,
                                 entries_after: count_ff};
               state_in      = S_IDLE;
            end else begin
               // old last slot is count+1, stored at address count
               mem_re   = 1'b1;
               mem_addr = count_ff[mhpq_pkg::ADDR_WIDTH-1:0];
               state_in = S_RM_LAST;
            end
         end
         S_RM_LAST: begin
            val_in   = mem_rdata;
            pos_in   = mhpq_pkg::POS_WIDTH'(1);
            state_in = S_DN_CHK;
         end
         S_DN_CHK: begin
            if (left_pos > last_pos) begin
               mem_we        = 1'b1;
               mem_addr      = slot_addr(pos_ff);
               rsp_strobe_in = 1'b1;
               rsp_in        = '{removed_value: removed_ff, status: mhpq_pkg::ST_DONE,
                                 entries_after: count_ff};
               state_in      = S_IDLE;
            end else begin
               mem_re      = 1'b1;
               mem_addr    = slot_addr(left_pos);
               right_ok_in = (left_pos < last_pos);
               state_in    = S_DN_LEFT;
            end
         end
         S_DN_LEFT: begin
            left_in = mem_rdata;
            if (right_ok_ff) begin
               mem_re   = 1'b1;
               mem_addr = slot_addr(right_pos);
            end
            state_in = S_DN_CMP;
         end
         S_DN_CMP: begin
            mem_we   = 1'b1;
            mem_addr = slot_addr(pos_ff);
            if ($signed(val_ff) < $signed(child_val)) begin
               mem_wdata = child_val;
               pos_in    = child_pos;
               state_in  = S_DN_CHK;
            end else begin
               rsp_strobe_in = 1'b1;
               rsp_in        = '{removed_value: removed_ff, status: mhpq_pkg::ST_DONE,
                                 entries_after: count_ff};
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         count_ff      <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         count_ff      <= count_in;
         rsp_strobe_ff <= rsp_strobe_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff      <= pos_in;
      val_ff      <= val_in;
      left_ff     <= left_in;
      removed_ff  <= removed_in;
      right_ok_ff <= right_ok_in;
      rsp_ff      <= rsp_in;
   end

   assign busy        = (state_ff != S_IDLE);
   assign rsp_strobe  = rsp_strobe_ff;
   assign rsp_payload = rsp_ff;

   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("response while sequencer busy");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= mhpq_pkg::CNT_WIDTH'(mhpq_pkg::HEAP_DEPTH))
      else $error("entry count beyond heap depth");

   a_accept_progress: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |=> (busy || rsp_strobe))
      else $error("accepted request produced neither work nor response");

   a_refused_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status != mhpq_pkg::ST_DONE))
         |-> (rsp_payload.removed_value == '0))
      else $error("refused request returned a value");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && (rsp_payload.status == mhpq_pkg::ST_FULL))
         |-> (rsp_payload.entries_after == mhpq_pkg::CNT_WIDTH'(mhpq_pkg::HEAP_DEPTH)))
      else $error("full status with heap not full");

endmodule
